### hdl/rtws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtws_pkg;

  localparam int unsigned PointW   = 5;
  localparam int unsigned TrialW   = 8;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned TapW     = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [PointW-1:0] MaxPoints    = 5'd31;
  localparam logic [PointW-1:0] MidPoint     = 5'd15;
  localparam logic              ModeResetVal = 1'b1;
  localparam logic [PointW-1:0] PointsReset  = 5'd31;
  localparam logic [TrialW-1:0] TrialsReset  = 8'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SWEEP_MODE = 2'd0,
    CFG_POINTS     = 2'd1,
    CFG_TRIALS     = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    MODE_PHASE = 1'b0,
    MODE_DELAY = 1'b1
  } sweep_mode_t;

  typedef struct packed {
    logic [PointW-1:0] point_to_apply;
    logic [PhaseW-1:0] phase_setting;
    logic [TapW-1:0]   data_delay;
    logic [TapW-1:0]   strobe_delay;
    logic              sweep_done;
    logic [PointW-1:0] window_length;
    logic              window_fail;
  } result_t;

  // Maps a sweep point onto the phase or delay-line settings.
  function automatic result_t point_settings(input logic mode, input logic [PointW-1:0] p);
    result_t r;
    logic [PointW-1:0] diff;
    r = '0;
    r.point_to_apply = p;
    if (mode == MODE_PHASE) begin
      r.phase_setting = p[PhaseW-1:0];
    end else if (p <= MidPoint) begin
      diff = MidPoint - p;
      r.strobe_delay = diff[TapW-1:0];
    end else begin
      diff = p - MidPoint;
      r.data_delay = diff[TapW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/rtws_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtws_in_if;
  logic valid;
  logic ready;
  logic trial_pass;

  modport source (output valid, output trial_pass, input ready);
  modport sink (input valid, input trial_pass, output ready);
endinterface

interface rtws_out_if;
  logic                         valid;
  logic                         ready;
  logic [rtws_pkg::PointW-1:0]  point_to_apply;
  logic [rtws_pkg::PhaseW-1:0]  phase_setting;
  logic [rtws_pkg::TapW-1:0]    data_delay;
  logic [rtws_pkg::TapW-1:0]    strobe_delay;
  logic                         sweep_done;
  logic [rtws_pkg::PointW-1:0]  window_length;
  logic                         window_fail;

  modport source (
    output valid, output point_to_apply, output phase_setting, output data_delay,
    output strobe_delay, output sweep_done, output window_length, output window_fail,
    input ready
  );
  modport sink (
    input valid, input point_to_apply, input phase_setting, input data_delay,
    input strobe_delay, input sweep_done, input window_length, input window_fail,
    output ready
  );
endinterface

`default_nettype wire

### hdl/read_timing_window_search.sv
// Read-timing window search: controller of a read-leveling calibration sweep.
// in_ch carries the pass/fail outcome of one test read made outside the block
// at the point last reported. Every input transfer yields exactly one result on
// out_ch: the point, phase and delay taps to program next, or, on the last trial
// of the last point, the chosen point with sweep_done, window_length and
// window_fail. The sweep then starts over at point 0.
// The cfg_ port writes sweep_mode, points_in_sweep and trials_per_point by
// index; write only while no transfer is in flight.
// The result of an input transfer is registered in the output register, or in
// the skid register while out_ch stalls. One input is taken every cycle while
// the skid entry is empty; result and counter updates are computed combinationally.
// A two-entry output stage (output register plus skid register) lets the block
// take a new input while an unread result waits. When out_ch stalls, the skid
// entry fills and in_ch.ready drops until the receiver takes a result.
// Synchronous active-low reset clears the sweep state and both output entries
// and restores the register defaults (delay mode, 31 points, 100 trials).
`timescale 1ns / 1ps
`default_nettype none

module read_timing_window_search (
  input  wire                              clk,
  input  wire                              rst_n,
  rtws_in_if.sink                          in_ch,
  rtws_out_if.source                       out_ch,
  input  wire                              cfg_we,
  input  wire [rtws_pkg::CfgIdxW-1:0]      cfg_idx,
  input  wire [rtws_pkg::CfgDataW-1:0]     cfg_wdata
);
  import rtws_pkg::*;

  logic              sweep_mode_r;
  logic [PointW-1:0] points_r;
  logic [TrialW-1:0] trials_r;

  logic [PointW-1:0] current_point_r, current_point_nxt;
  logic [TrialW-1:0] trial_count_r, trial_count_nxt;
  logic [TrialW-1:0] hit_count_r, hit_count_nxt;
  logic [PointW-1:0] run_length_r, run_length_nxt;
  logic [PointW-1:0] best_length_r, best_length_nxt;
  logic [PointW-1:0] best_end_r, best_end_nxt;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;

  logic              in_xfer, out_xfer;
  logic [TrialW-1:0] ntr;
  logic [PointW-1:0] npts;
  logic [TrialW:0]   done_trials, hits;
  logic              point_end, good, last_point, new_best, fail;
  logic [PointW-1:0] run_inc, next_point, choice, half_len;
  logic [PointW:0]   point_inc;
  result_t           res;

  assign in_ch.ready = !skid_valid_r;
  assign in_xfer     = in_ch.valid && !skid_valid_r;
  assign out_xfer    = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_mode_r <= ModeResetVal;
      points_r     <= PointsReset;
      trials_r     <= TrialsReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SWEEP_MODE: sweep_mode_r <= cfg_wdata[0];
        CFG_POINTS:     points_r     <= cfg_wdata[PointW-1:0];
        CFG_TRIALS:     trials_r     <= cfg_wdata[TrialW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ntr = (trials_r == '0) ? TrialW'(1) : trials_r;
    if (points_r == '0) begin
      npts = PointW'(1);
    end else if (points_r > MaxPoints) begin
      npts = MaxPoints;
    end else begin
      npts = points_r;
    end

    done_trials = {1'b0, trial_count_r} + (TrialW+1)'(1);
    hits        = {1'b0, hit_count_r} + {{TrialW{1'b0}}, in_ch.trial_pass};
    point_end   = done_trials >= {1'b0, ntr};
    good        = hits == done_trials;

    run_inc   = run_length_r + PointW'(1);
    new_best  = good && (run_inc > best_length_r);
    point_inc = {1'b0, current_point_r} + (PointW+1)'(1);
    last_point = point_inc >= {1'b0, npts};
    next_point = point_inc[PointW-1:0];

    current_point_nxt = current_point_r;
    trial_count_nxt   = done_trials[TrialW-1:0];
    hit_count_nxt     = hits[TrialW-1:0];
    run_length_nxt    = run_length_r;
    best_length_nxt   = best_length_r;
    best_end_nxt      = best_end_r;
    fail              = 1'b0;
    choice            = '0;
    half_len          = '0;
    res               = point_settings(sweep_mode_r, current_point_r);

    if (point_end) begin
      trial_count_nxt = '0;
      hit_count_nxt   = '0;
      run_length_nxt  = good ? run_inc : '0;
      if (new_best) begin
        best_length_nxt = run_inc;
        best_end_nxt    = current_point_r;
      end
      if (!last_point) begin
        current_point_nxt = next_point;
        res = point_settings(sweep_mode_r, next_point);
      end else begin
        // The whole sweep is done: report the window and start over.
        half_len = best_length_nxt >> 1;
        if (sweep_mode_r == MODE_PHASE) begin
          fail = best_length_nxt == '0;
          if (!fail) choice = best_end_nxt + PointW'(1) - best_length_nxt;
        end else begin
          fail = best_length_nxt <= PointW'(1);
          if (!fail) choice = best_end_nxt - half_len;
        end
        res = point_settings(sweep_mode_r, choice);
        res.sweep_done    = 1'b1;
        res.window_length = best_length_nxt;
        res.window_fail   = fail;
        current_point_nxt = '0;
        run_length_nxt    = '0;
        best_length_nxt   = '0;
        best_end_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_point_r <= '0;
      trial_count_r   <= '0;
      hit_count_r     <= '0;
      run_length_r    <= '0;
      best_length_r   <= '0;
      best_end_r      <= '0;
    end else if (in_xfer) begin
      current_point_r <= current_point_nxt;
      trial_count_r   <= trial_count_nxt;
      hit_count_r     <= hit_count_nxt;
      run_length_r    <= run_length_nxt;
      best_length_r   <= best_length_nxt;
      best_end_r      <= best_end_nxt;
    end
  end

  // Output stage: the skid entry drains into the output register first.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_xfer || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_xfer;
        out_data_nxt  = res;
      end
    end else if (in_xfer) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.point_to_apply = out_data_r.point_to_apply;
  assign out_ch.phase_setting  = out_data_r.phase_setting;
  assign out_ch.data_delay     = out_data_r.data_delay;
  assign out_ch.strobe_delay   = out_data_r.strobe_delay;
  assign out_ch.sweep_done     = out_data_r.sweep_done;
  assign out_ch.window_length  = out_data_r.window_length;
  assign out_ch.window_fail    = out_data_r.window_fail;

endmodule

`default_nettype wire

### hdl/rtws_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rtws_checker (
  input wire                           clk,
  input wire                           rst_n,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [rtws_pkg::PointW-1:0]    point_to_apply,
  input wire [rtws_pkg::PhaseW-1:0]    phase_setting,
  input wire [rtws_pkg::TapW-1:0]      data_delay,
  input wire [rtws_pkg::TapW-1:0]      strobe_delay,
  input wire                           sweep_done,
  input wire [rtws_pkg::PointW-1:0]    window_length,
  input wire                           window_fail
);
  import rtws_pkg::*;

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // Window report fields stay clear on intermediate results.
  a_window_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !sweep_done |-> window_length == '0 && !window_fail)
    else $error("window report outside sweep end");

  a_fail_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sweep_done && window_fail |-> point_to_apply == '0)
    else $error("failed window did not pick point 0");

  // Phase and delay settings never appear together.
  a_mode_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && phase_setting != '0 |-> data_delay == '0 && strobe_delay == '0)
    else $error("phase and delay settings both driven");

endmodule

bind read_timing_window_search rtws_checker u_rtws_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .point_to_apply (out_ch.point_to_apply),
  .phase_setting  (out_ch.phase_setting),
  .data_delay     (out_ch.data_delay),
  .strobe_delay   (out_ch.strobe_delay),
  .sweep_done     (out_ch.sweep_done),
  .window_length  (out_ch.window_length),
  .window_fail    (out_ch.window_fail)
);

`default_nettype wire
